@@ rtl/assert_macros.svh @@
// assertion macros used by the top level to check its own logic
// depends on nothing; pulled in by the top level with a plain include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define CHK_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define CHK_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fslt_pkg.sv @@
// shared constants, types and the adaptive step function of the light tracker
// depends on nothing; used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package fslt_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int NUM_CH      = 4;
    localparam int CH_BITS     = 2;
    localparam int IN_BITS     = NUM_CH * SAMPLE_BITS;
    localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;

    localparam int PULSE_BITS     = 12;
    localparam int OUT_MOVED_BIT  = 2 * PULSE_BITS;
    localparam int OUT_VALID_BIT  = 2 * PULSE_BITS + 1;
    localparam int OUT_FIELD_BITS = 2 * PULSE_BITS + 2;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 12;

    localparam int MAG_BITS = (SAMPLE_BITS > 11) ? SAMPLE_BITS : 11;
    localparam int SUM_BITS = (SAMPLE_BITS + 2 > 12) ? SAMPLE_BITS + 2 : 12;
    localparam int STEP_BITS = 6;

    localparam int LOST_BITS  = 5;
    localparam int HCNT_BITS  = 6;
    localparam int HOMING_CAP = 43;

    localparam logic [PULSE_BITS-1:0] PULSE_CENTRE = 12'd1500;
    localparam logic [PULSE_BITS-1:0] PULSE_MIN    = 12'd600;
    localparam logic [PULSE_BITS-1:0] PULSE_MAX    = 12'd2400;

    localparam logic [STEP_BITS-1:0] STEP_MIN = 6'd10;
    localparam logic [STEP_BITS-1:0] STEP_MAX = 6'd40;
    localparam int STEP_GAIN     = 15;
    localparam int STEP_SAT_MAG  = 40 * STEP_GAIN;
    // 2185 / 2^15 gives an exact floor(x / 15) for x below the saturation point
    localparam int STEP_RECIP    = 2185;
    localparam int RECIP_SHIFT   = 15;
    localparam int RECIP_IN_BITS = 10;
    localparam int RECIP_PROD_BITS = 22;

    localparam logic [LOST_BITS-1:0] LOST_SAT = 5'd31;

    localparam logic [7:0]  RST_ALPHA     = 8'd200;
    localparam logic [9:0]  RST_DEADBAND  = 10'd30;
    localparam logic [9:0]  RST_MIN_LEVEL = 10'd50;
    localparam logic [11:0] RST_TOTAL_THR = 12'd400;
    localparam logic [3:0]  RST_LOST_LIM  = 4'd3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ALPHA     = 3'd0,
        REG_DEADBAND  = 3'd1,
        REG_MIN_LEVEL = 3'd2,
        REG_TOTAL_THR = 3'd3,
        REG_LOST_LIM  = 3'd4
    } cfg_reg_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_FILT  = 7'b0000010,
        ST_CHECK = 7'b0000100,
        ST_TMAG  = 7'b0001000,
        ST_HMAG  = 7'b0010000,
        ST_STEP  = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic               load_in;
        logic               filt_en;
        logic [CH_BITS-1:0] ch;
        logic               check_en;
        logic               tmag_en;
        logic               hmag_en;
        logic               step_en;
        logic               emit_en;
        logic               emit_homing;
        logic               emit_last;
    } cmd_t;

    typedef struct packed {
        logic home_trig;
        logic centred;
        logic out_free;
    } sts_t;

    function automatic logic [STEP_BITS-1:0] adaptive_step(input logic [MAG_BITS-1:0] mag);
        logic [RECIP_PROD_BITS-1:0] prod;
        logic [STEP_BITS-1:0]       quo;
        logic [STEP_BITS-1:0]       step;
        prod = RECIP_PROD_BITS'(mag[RECIP_IN_BITS-1:0]) * RECIP_PROD_BITS'(STEP_RECIP);
        quo  = prod[RECIP_SHIFT +: STEP_BITS];
        if (mag >= MAG_BITS'(STEP_SAT_MAG)) begin
            step = STEP_MAX;
        end else if (quo < STEP_MIN) begin
            step = STEP_MIN;
        end else begin
            step = quo;
        end
        return step;
    endfunction

endpackage

@@ rtl/fslt_ctrl.sv @@
// sequencing state machine of the light tracker: filter sweep, light check,
// tracking move, homing run or plain result, result hand-off; depends on fslt_pkg
`timescale 1ns / 1ps

module fslt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  fslt_pkg::sts_t  sts,
    output fslt_pkg::cmd_t  cmd
);

    fslt_pkg::state_t                  state_reg, state_next;
    logic [fslt_pkg::CH_BITS-1:0]      ch_reg, ch_next;
    logic [fslt_pkg::HCNT_BITS-1:0]    hcnt_reg, hcnt_next;
    logic                              run_home_reg, run_home_next;
    logic                              last_step;

    assign s_tready  = (state_reg == fslt_pkg::ST_IDLE);
    assign last_step = !run_home_reg || sts.centred ||
                       (hcnt_reg == fslt_pkg::HCNT_BITS'(fslt_pkg::HOMING_CAP - 1));

    always_comb begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        hcnt_next     = hcnt_reg;
        run_home_next = run_home_reg;
        cmd           = '0;
        cmd.ch        = ch_reg;
        case (state_reg)
            fslt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    ch_next     = '0;
                    state_next  = fslt_pkg::ST_FILT;
                end
            end
            fslt_pkg::ST_FILT: begin
                cmd.filt_en = 1'b1;
                ch_next     = ch_reg + 1'b1;
                if (ch_reg == fslt_pkg::CH_BITS'(fslt_pkg::NUM_CH - 1)) begin
                    state_next = fslt_pkg::ST_CHECK;
                end
            end
            fslt_pkg::ST_CHECK: begin
                cmd.check_en = 1'b1;
                hcnt_next    = '0;
                if (sts.home_trig && !sts.centred) begin
                    run_home_next = 1'b1;
                    state_next    = fslt_pkg::ST_HMAG;
                end else if (sts.home_trig) begin
                    // already centred: one plain result, no move
                    run_home_next = 1'b0;
                    state_next    = fslt_pkg::ST_EMIT;
                end else begin
                    run_home_next = 1'b0;
                    state_next    = fslt_pkg::ST_TMAG;
                end
            end
            fslt_pkg::ST_TMAG: begin
                cmd.tmag_en = 1'b1;
                state_next  = fslt_pkg::ST_STEP;
            end
            fslt_pkg::ST_HMAG: begin
                cmd.hmag_en = 1'b1;
                state_next  = fslt_pkg::ST_STEP;
            end
            fslt_pkg::ST_STEP: begin
                cmd.step_en = 1'b1;
                state_next  = fslt_pkg::ST_EMIT;
            end
            fslt_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_en     = 1'b1;
                    cmd.emit_homing = run_home_reg;
                    cmd.emit_last   = last_step;
                    if (last_step) begin
                        state_next = fslt_pkg::ST_IDLE;
                    end else begin
                        hcnt_next  = hcnt_reg + 1'b1;
                        state_next = fslt_pkg::ST_HMAG;
                    end
                end
            end
            default: begin
                state_next = fslt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fslt_pkg::ST_IDLE;
            ch_reg       <= '0;
            hcnt_reg     <= '0;
            run_home_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ch_reg       <= ch_next;
            hcnt_reg     <= hcnt_next;
            run_home_reg <= run_home_next;
        end
    end

endmodule

@@ rtl/fslt_datapath.sv @@
// datapath of the light tracker: config registers, shared filter multiplier,
// light check, axis step unit, pulse state and output register; depends on fslt_pkg
`timescale 1ns / 1ps

module fslt_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [fslt_pkg::IN_TDATA_BITS-1:0]    s_tdata,
    input  logic                                  cfg_valid,
    input  logic [fslt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [fslt_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [fslt_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
    output logic                                  m_tlast,
    output logic                                  m_tuser,
    input  fslt_pkg::cmd_t                        cmd,
    output fslt_pkg::sts_t                        sts
);

    localparam int SB   = fslt_pkg::SAMPLE_BITS;
    localparam int PB   = fslt_pkg::PULSE_BITS;
    localparam int MB   = fslt_pkg::MAG_BITS;
    localparam int PROD = SB + 10;

    // configuration
    logic [7:0]  alpha_reg;
    logic [9:0]  deadband_reg;
    logic [9:0]  min_level_reg;
    logic [11:0] total_thr_reg;
    logic [3:0]  lost_lim_reg;

    // tracker state
    logic [SB-1:0] raw_reg   [fslt_pkg::NUM_CH];
    logic [SB-1:0] level_reg [fslt_pkg::NUM_CH];
    logic          seeded_reg;
    logic [fslt_pkg::LOST_BITS-1:0] lost_reg;
    logic          valid_reg, moved_reg, home_mode_reg;
    logic [PB-1:0] az_reg, tilt_reg;

    // per-axis move staging
    logic [MB-1:0] az_mag_reg, tl_mag_reg;
    logic          az_up_reg, tl_up_reg, az_act_reg, tl_act_reg;

    // output register
    logic          m_valid_reg;
    logic [PB-1:0] m_az_reg, m_tilt_reg;
    logic          m_moved_reg, m_light_reg, m_homing_reg, m_last_reg;

    // filter
    logic [SB-1:0]        raw_sel, old_sel, level_next;
    logic signed [SB:0]   diff;
    logic signed [PROD-1:0] prod, filt_sum;

    assign raw_sel  = raw_reg[cmd.ch];
    assign old_sel  = level_reg[cmd.ch];
    assign diff     = $signed({1'b0, raw_sel}) - $signed({1'b0, old_sel});
    assign prod     = PROD'($signed({1'b0, alpha_reg}) * diff);
    assign filt_sum = $signed(PROD'({1'b0, old_sel})) + (prod >>> 8);
    assign level_next = seeded_reg ? filt_sum[SB-1:0] : raw_sel;

    // light check
    logic [fslt_pkg::NUM_CH-1:0]   lit;
    logic [fslt_pkg::SUM_BITS-1:0] total;
    logic [2:0]                    lit_cnt;
    logic                          light_ok;
    logic [fslt_pkg::LOST_BITS-1:0] lost_inc;

    always_comb begin
        total   = '0;
        lit_cnt = '0;
        for (int i = 0; i < fslt_pkg::NUM_CH; i++) begin
            lit[i] = fslt_pkg::SUM_BITS'(level_reg[i]) > fslt_pkg::SUM_BITS'(min_level_reg);
            if (lit[i]) begin
                total   = total + fslt_pkg::SUM_BITS'(level_reg[i]);
                lit_cnt = lit_cnt + 3'd1;
            end
        end
    end

    assign light_ok = (lit_cnt >= 3'd2) && (total > fslt_pkg::SUM_BITS'(total_thr_reg));
    assign lost_inc = (lost_reg == fslt_pkg::LOST_SAT) ? lost_reg : lost_reg + 1'b1;

    assign sts.home_trig = !light_ok && (fslt_pkg::LOST_BITS'(lost_lim_reg) < lost_inc);
    assign sts.centred   = (az_reg == fslt_pkg::PULSE_CENTRE) &&
                           (tilt_reg == fslt_pkg::PULSE_CENTRE);
    assign sts.out_free  = !m_valid_reg || m_tready;

    // axis magnitudes
    logic [SB-1:0] lside_avg, rside_avg, top_avg, bot_avg;
    logic [SB:0]   sum_l, sum_r, sum_t, sum_b;
    logic [MB-1:0] az_tmag, tl_tmag, az_hmag, tl_hmag;
    logic [PB-1:0] az_herr, tl_herr;

    assign sum_l = {1'b0, level_reg[0]} + {1'b0, level_reg[2]};
    assign sum_r = {1'b0, level_reg[1]} + {1'b0, level_reg[3]};
    assign sum_t = {1'b0, level_reg[0]} + {1'b0, level_reg[1]};
    assign sum_b = {1'b0, level_reg[2]} + {1'b0, level_reg[3]};
    assign lside_avg = sum_l[SB:1];
    assign rside_avg = sum_r[SB:1];
    assign top_avg   = sum_t[SB:1];
    assign bot_avg   = sum_b[SB:1];

    assign az_tmag = MB'((lside_avg > rside_avg) ? lside_avg - rside_avg
                                                 : rside_avg - lside_avg);
    assign tl_tmag = MB'((top_avg > bot_avg) ? top_avg - bot_avg : bot_avg - top_avg);
    assign az_herr = (az_reg > fslt_pkg::PULSE_CENTRE) ? az_reg - fslt_pkg::PULSE_CENTRE
                                                       : fslt_pkg::PULSE_CENTRE - az_reg;
    assign tl_herr = (tilt_reg > fslt_pkg::PULSE_CENTRE) ? tilt_reg - fslt_pkg::PULSE_CENTRE
                                                         : fslt_pkg::PULSE_CENTRE - tilt_reg;
    assign az_hmag = MB'(az_herr);
    assign tl_hmag = MB'(tl_herr);

    // step unit, both axes
    logic [fslt_pkg::STEP_BITS-1:0] az_step, tl_step;
    logic [PB-1:0] az_next, tilt_next;

    assign az_step = fslt_pkg::adaptive_step(az_mag_reg);
    assign tl_step = fslt_pkg::adaptive_step(tl_mag_reg);

    function automatic logic [PB-1:0] move_axis(
        input logic [PB-1:0]                  p,
        input logic [MB-1:0]                  mag,
        input logic [fslt_pkg::STEP_BITS-1:0] step,
        input logic                           up,
        input logic                           act,
        input logic                           home
    );
        logic [PB:0]   up_sum;
        logic [PB-1:0] dn_val;
        logic [PB-1:0] res;
        up_sum = {1'b0, p} + (PB + 1)'(step);
        dn_val = p - PB'(step);
        if (home && (mag <= MB'(step))) begin
            res = fslt_pkg::PULSE_CENTRE;
        end else if (!act) begin
            res = p;
        end else if (up) begin
            if (!home && (up_sum > (PB + 1)'(fslt_pkg::PULSE_MAX))) begin
                res = fslt_pkg::PULSE_MAX;
            end else begin
                res = up_sum[PB-1:0];
            end
        end else begin
            if (!home && (dn_val < fslt_pkg::PULSE_MIN)) begin
                res = fslt_pkg::PULSE_MIN;
            end else begin
                res = dn_val;
            end
        end
        return res;
    endfunction

    assign az_next   = move_axis(az_reg, az_mag_reg, az_step, az_up_reg, az_act_reg,
                                 home_mode_reg);
    assign tilt_next = move_axis(tilt_reg, tl_mag_reg, tl_step, tl_up_reg, tl_act_reg,
                                 home_mode_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg     <= fslt_pkg::RST_ALPHA;
            deadband_reg  <= fslt_pkg::RST_DEADBAND;
            min_level_reg <= fslt_pkg::RST_MIN_LEVEL;
            total_thr_reg <= fslt_pkg::RST_TOTAL_THR;
            lost_lim_reg  <= fslt_pkg::RST_LOST_LIM;
            for (int i = 0; i < fslt_pkg::NUM_CH; i++) begin
                level_reg[i] <= '0;
            end
            seeded_reg  <= 1'b0;
            lost_reg    <= '0;
            az_reg      <= fslt_pkg::PULSE_CENTRE;
            tilt_reg    <= fslt_pkg::PULSE_CENTRE;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    fslt_pkg::REG_ALPHA:     alpha_reg     <= cfg_data[7:0];
                    fslt_pkg::REG_DEADBAND:  deadband_reg  <= cfg_data[9:0];
                    fslt_pkg::REG_MIN_LEVEL: min_level_reg <= cfg_data[9:0];
                    fslt_pkg::REG_TOTAL_THR: total_thr_reg <= cfg_data[11:0];
                    fslt_pkg::REG_LOST_LIM:  lost_lim_reg  <= cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.filt_en) begin
                level_reg[cmd.ch] <= level_next;
                if (cmd.ch == fslt_pkg::CH_BITS'(fslt_pkg::NUM_CH - 1)) begin
                    seeded_reg <= 1'b1;
                end
            end
            if (cmd.check_en) begin
                if (light_ok || sts.home_trig) begin
                    lost_reg <= '0;
                end else begin
                    lost_reg <= lost_inc;
                end
            end
            if (cmd.step_en) begin
                az_reg   <= az_next;
                tilt_reg <= tilt_next;
            end
            if (cmd.emit_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            for (int i = 0; i < fslt_pkg::NUM_CH; i++) begin
                raw_reg[i] <= s_tdata[i*SB +: SB];
            end
        end
        if (cmd.check_en) begin
            valid_reg <= light_ok;
            moved_reg <= 1'b0;
        end
        if (cmd.tmag_en) begin
            home_mode_reg <= 1'b0;
            az_mag_reg    <= az_tmag;
            az_up_reg     <= lside_avg > rside_avg;
            az_act_reg    <= az_tmag > MB'(deadband_reg);
            tl_mag_reg    <= tl_tmag;
            tl_up_reg     <= top_avg > bot_avg;
            tl_act_reg    <= tl_tmag > MB'(deadband_reg);
        end
        if (cmd.hmag_en) begin
            home_mode_reg <= 1'b1;
            az_mag_reg    <= az_hmag;
            az_up_reg     <= az_reg < fslt_pkg::PULSE_CENTRE;
            az_act_reg    <= 1'b1;
            tl_mag_reg    <= tl_hmag;
            tl_up_reg     <= tilt_reg < fslt_pkg::PULSE_CENTRE;
            tl_act_reg    <= 1'b1;
        end
        if (cmd.step_en && !home_mode_reg && (az_act_reg || tl_act_reg)) begin
            moved_reg <= 1'b1;
        end
        if (cmd.emit_en) begin
            m_az_reg     <= az_reg;
            m_tilt_reg   <= tilt_reg;
            m_moved_reg  <= moved_reg;
            m_light_reg  <= valid_reg;
            m_homing_reg <= cmd.emit_homing;
            m_last_reg   <= cmd.emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(fslt_pkg::OUT_TDATA_BITS - fslt_pkg::OUT_FIELD_BITS)'(0),
                       m_light_reg, m_moved_reg, m_tilt_reg, m_az_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_homing_reg;

endmodule

@@ rtl/four_sensor_light_tracker_top.sv @@
// top level of the four-sensor light tracker: controller plus datapath
// depends on fslt_pkg, fslt_ctrl, fslt_datapath and assert_macros.svh
//
// usage:
//   s_* channel takes one word per sensor frame: four raw samples in s_tdata.
//   m_* channel gives the result words; m_tlast marks the final word of a
//   frame, m_tuser flags a return-to-centre step.
//   cfg_* channel writes a register by index (0 alpha, 1 deadband,
//   2 min level, 3 total threshold, 4 lost limit); always ready, writes are
//   expected while the block is idle, unknown indexes are dropped.
// sequence:
//   a tracking frame runs through the filter sweep (one channel per cycle through
//   a shared multiplier), the light check, the magnitude and the step state, and
//   its result is then registered in the emit state; the next frame is taken
//   once the controller is back in idle. a homing run repeats magnitude, step and
//   emit for each further homing step (up to 43 steps per frame).
// reset: synchronous active-low aresetn restores the register defaults,
//   clears the filter and loss counter and centres both pulses at 1500 us.
// stall: a held m_tready keeps the result in the output register; the block
//   still accepts the next frame and waits before handing over its result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module four_sensor_light_tracker_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // tl, tr, bl, br samples from the low bits up
    input  logic [fslt_pkg::IN_TDATA_BITS-1:0]    s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // azimuth_pulse_us, tilt_pulse_us, moved, light_valid, zero pad
    output logic [fslt_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
    // homing
    output logic                                  m_tuser,
    output logic                                  m_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fslt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [fslt_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    fslt_pkg::cmd_t cmd;
    fslt_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    fslt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fslt_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

    `CHK_IMPLIES(a_pulse_range, aclk, aresetn, m_tvalid,
        (m_tdata[fslt_pkg::PULSE_BITS-1:0] >= fslt_pkg::PULSE_MIN) && (m_tdata[fslt_pkg::PULSE_BITS-1:0] <= fslt_pkg::PULSE_MAX), "azimuth pulse out of range")
    `CHK_IMPLIES(a_homing_flags, aclk, aresetn, m_tvalid && m_tuser,
        !m_tdata[fslt_pkg::OUT_MOVED_BIT] && !m_tdata[fslt_pkg::OUT_VALID_BIT], "homing word with move or light flag")
    `CHK_IMPLIES(a_nonlast_homing, aclk, aresetn, m_tvalid && !m_tlast, m_tuser,
        "non-final word outside a homing run")
    `CHK_IMPLIES(a_emit_free, aclk, aresetn, cmd.emit_en, sts.out_free,
        "result loaded over an untaken word")
    `CHK_NEXT(a_one_frame, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "new frame taken while one is in progress")

endmodule
